// ===== rtl/core/central_face_flux_2d_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef CENTRAL_FACE_FLUX_2D_CORE_DEFINES_SVH
`define CENTRAL_FACE_FLUX_2D_CORE_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define CFFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cffd assertion failed");

// Next-cycle implication, disabled while rst is high.
`define CFFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cffd assertion failed");

`endif

// ===== rtl/core/cffd_pkg.sv =====
package cffd_pkg;

   // Quotient bits produced by the velocity divider, one per stage.
   localparam int DIV_BITS = 33;
   // Product, dot, magnitude, divider load, divider stages, clip.
   localparam int CONTRA_LAT = 5 + DIV_BITS;
   // Operand, multiply, sum, clip.
   localparam int FLUX_LAT = 4;
   localparam int PIPE_LAT = CONTRA_LAT + FLUX_LAT;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   // Half of 2^17: round half up on the final shift.
   localparam logic signed [65:0] FLUX_RND = 66'sd65536;

   typedef struct packed {
      logic        [30:0] left_density;
      logic signed [31:0] left_xmom;
      logic signed [31:0] left_ymom;
      logic signed [31:0] left_energy;
      logic        [30:0] left_pressure;
      logic        [30:0] right_density;
      logic signed [31:0] right_xmom;
      logic signed [31:0] right_ymom;
      logic signed [31:0] right_energy;
      logic        [30:0] right_pressure;
      logic signed [31:0] face_nx;
      logic signed [31:0] face_ny;
   } item_type;

   typedef struct packed {
      logic signed [31:0] mass_flux;
      logic signed [31:0] xmom_flux;
      logic signed [31:0] ymom_flux;
      logic signed [31:0] energy_flux;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] qs;
      logic               sat;
   } velo_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               sat;
   } clip_type;

   // Shift a rounded flux sum down by 17 and clip it to 32 bits.
   function automatic clip_type clip_flux(input logic signed [65:0] s);
      clip_type r;
      if (s[65:48] == '0 || s[65:48] == '1) begin
         r.val = s[48:17];
         r.sat = 1'b0;
      end else if (s[65]) begin
         r.val = Q_MIN;
         r.sat = 1'b1;
      end else begin
         r.val = Q_MAX;
         r.sat = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/cffd_channels.sv =====
interface cffd_req_if;
   logic               valid;
   logic               ready;
   logic        [30:0] left_density;
   logic signed [31:0] left_xmom;
   logic signed [31:0] left_ymom;
   logic signed [31:0] left_energy;
   logic        [30:0] left_pressure;
   logic        [30:0] right_density;
   logic signed [31:0] right_xmom;
   logic signed [31:0] right_ymom;
   logic signed [31:0] right_energy;
   logic        [30:0] right_pressure;
   logic signed [31:0] face_nx;
   logic signed [31:0] face_ny;

   modport source (output valid, left_density, left_xmom, left_ymom, left_energy,
                   left_pressure, right_density, right_xmom, right_ymom, right_energy,
                   right_pressure, face_nx, face_ny, input ready);
   modport sink (input valid, left_density, left_xmom, left_ymom, left_energy,
                 left_pressure, right_density, right_xmom, right_ymom, right_energy,
                 right_pressure, face_nx, face_ny, output ready);
endinterface

interface cffd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] mass_flux;
   logic signed [31:0] xmom_flux;
   logic signed [31:0] ymom_flux;
   logic signed [31:0] energy_flux;
   logic               saturated;

   modport source (output valid, mass_flux, xmom_flux, ymom_flux, energy_flux,
                   saturated, input ready);
   modport sink (input valid, mass_flux, xmom_flux, ymom_flux, energy_flux,
                 saturated, output ready);
endinterface

// ===== rtl/core/central_face_flux_2d_core.sv =====
// Central averaged 2-D Euler face flux, Q16.16, fully pipelined.
// Path: an accepted req word runs through the velocity path, mostly the
// 33-stage bit-per-stage divider, then the flux path and the output register.
// Throughput: one face per cycle while the output is not stalled; the output skid stage absorbs one extra word.
// Reset: synchronous, clears the stage valid bits and the output stage.
module central_face_flux_2d_core (
   input logic        clock,
   input logic        reset,
   cffd_req_if.sink   req_ch,
   cffd_rsp_if.source rsp_ch
);

   logic               adv;
   cffd_pkg::item_type item_in;
   cffd_pkg::item_type item_ff [0:cffd_pkg::CONTRA_LAT-1];
   logic               vld_ff  [0:cffd_pkg::PIPE_LAT-1];
   cffd_pkg::velo_type velo_l, velo_r;
   cffd_pkg::rsp_type  flux, out_word;

   assign item_in.left_density   = req_ch.left_density;
   assign item_in.left_xmom      = req_ch.left_xmom;
   assign item_in.left_ymom      = req_ch.left_ymom;
   assign item_in.left_energy    = req_ch.left_energy;
   assign item_in.left_pressure  = req_ch.left_pressure;
   assign item_in.right_density  = req_ch.right_density;
   assign item_in.right_xmom     = req_ch.right_xmom;
   assign item_in.right_ymom     = req_ch.right_ymom;
   assign item_in.right_energy   = req_ch.right_energy;
   assign item_in.right_pressure = req_ch.right_pressure;
   assign item_in.face_nx        = req_ch.face_nx;
   assign item_in.face_ny        = req_ch.face_ny;

   assign req_ch.ready = adv;

   // Advance valid bits with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cffd_pkg::PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_ch.valid;
         for (int i = 1; i < cffd_pkg::PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Delay the face word to meet the velocities.
   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= item_in;
         for (int i = 1; i < cffd_pkg::CONTRA_LAT; i++) begin
            item_ff[i] <= item_ff[i-1];
         end
      end
   end

   cffd_contra u_contra_l (
      .clock (clock),
      .en    (adv),
      .xmom  (req_ch.left_xmom),
      .ymom  (req_ch.left_ymom),
      .nx    (req_ch.face_nx),
      .ny    (req_ch.face_ny),
      .rho   (req_ch.left_density),
      .velo  (velo_l)
   );

   cffd_contra u_contra_r (
      .clock (clock),
      .en    (adv),
      .xmom  (req_ch.right_xmom),
      .ymom  (req_ch.right_ymom),
      .nx    (req_ch.face_nx),
      .ny    (req_ch.face_ny),
      .rho   (req_ch.right_density),
      .velo  (velo_r)
   );

   cffd_flux u_flux (
      .clock  (clock),
      .en     (adv),
      .item   (item_ff[cffd_pkg::CONTRA_LAT-1]),
      .velo_l (velo_l),
      .velo_r (velo_r),
      .flux   (flux)
   );

   cffd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[cffd_pkg::PIPE_LAT-1]),
      .in_ready  (adv),
      .in_word   (flux),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_word  (out_word)
   );

   assign rsp_ch.mass_flux   = out_word.mass_flux;
   assign rsp_ch.xmom_flux   = out_word.xmom_flux;
   assign rsp_ch.ymom_flux   = out_word.ymom_flux;
   assign rsp_ch.energy_flux = out_word.energy_flux;
   assign rsp_ch.saturated   = out_word.saturated;

endmodule

// ===== rtl/core/cffd_contra.sv =====
module cffd_contra (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] xmom,
   input  logic signed [31:0] ymom,
   input  logic signed [31:0] nx,
   input  logic signed [31:0] ny,
   input  logic        [30:0] rho,
   output cffd_pkg::velo_type velo
);

   logic signed [63:0] p1_ff, p2_ff;
   logic        [30:0] rho1_ff, rho2_ff, rho3_ff;
   logic signed [64:0] dot_ff;
   logic               neg3_ff;
   logic        [63:0] mag3_ff;

   logic [30:0] rem_ff [0:cffd_pkg::DIV_BITS];
   logic [32:0] low_ff [0:cffd_pkg::DIV_BITS];
   logic [32:0] quo_ff [0:cffd_pkg::DIV_BITS];
   logic [30:0] rho_ff [0:cffd_pkg::DIV_BITS];
   logic        neg_ff [0:cffd_pkg::DIV_BITS];
   logic        ovf_ff [0:cffd_pkg::DIV_BITS];

   cffd_pkg::velo_type velo_ff;

   // Form the products, force zero density to one LSB.
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= xmom * nx;
         p2_ff   <= ymom * ny;
         rho1_ff <= (rho == '0) ? 31'd1 : rho;
      end
   end

   // Add the products, then take sign and magnitude.
   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff  <= 65'(p1_ff) + 65'(p2_ff);
         rho2_ff <= rho1_ff;
         neg3_ff <= dot_ff[64];
         mag3_ff <= dot_ff[64] ? 64'(-dot_ff) : dot_ff[63:0];
         rho3_ff <= rho2_ff;
      end
   end

   // Load the divider; a quotient of 2^33 or more is flagged as overflow.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= mag3_ff[63:33];
         low_ff[0] <= mag3_ff[32:0];
         quo_ff[0] <= '0;
         rho_ff[0] <= rho3_ff;
         neg_ff[0] <= neg3_ff;
         ovf_ff[0] <= (mag3_ff[63:33] >= rho3_ff);
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 1; k <= cffd_pkg::DIV_BITS; k++) begin : g_div
      logic [31:0] trial;
      logic [31:0] diff;
      logic        ge;

      assign trial = {rem_ff[k-1], low_ff[k-1][32]};
      assign diff  = trial - {1'b0, rho_ff[k-1]};
      assign ge    = (trial >= {1'b0, rho_ff[k-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[30:0] : trial[30:0];
            low_ff[k] <= {low_ff[k-1][31:0], 1'b0};
            quo_ff[k] <= {quo_ff[k-1][31:0], ge};
            rho_ff[k] <= rho_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   // Apply the sign and clip to the 32 bit range.
   always_ff @(posedge clock) begin
      if (en) begin
         if (!neg_ff[cffd_pkg::DIV_BITS]) begin
            if (ovf_ff[cffd_pkg::DIV_BITS] || quo_ff[cffd_pkg::DIV_BITS][32:31] != 2'b00) begin
               velo_ff.qs  <= cffd_pkg::Q_MAX;
               velo_ff.sat <= 1'b1;
            end else begin
               velo_ff.qs  <= {1'b0, quo_ff[cffd_pkg::DIV_BITS][30:0]};
               velo_ff.sat <= 1'b0;
            end
         end else begin
            if (ovf_ff[cffd_pkg::DIV_BITS] || quo_ff[cffd_pkg::DIV_BITS] > 33'h0_8000_0000) begin
               velo_ff.qs  <= cffd_pkg::Q_MIN;
               velo_ff.sat <= 1'b1;
            end else begin
               velo_ff.qs  <= 32'(-quo_ff[cffd_pkg::DIV_BITS]);
               velo_ff.sat <= 1'b0;
            end
         end
      end
   end

   assign velo = velo_ff;

endmodule

// ===== rtl/core/cffd_flux.sv =====
module cffd_flux (
   input  logic               clock,
   input  logic               en,
   input  cffd_pkg::item_type item,
   input  cffd_pkg::velo_type velo_l,
   input  cffd_pkg::velo_type velo_r,
   output cffd_pkg::rsp_type  flux
);

   logic signed [31:0] ql_ff, qr_ff, xl_ff, xr_ff, yl_ff, yr_ff, nx_ff, ny_ff;
   logic        [30:0] rl_ff, rr_ff;
   logic        [31:0] psum_ff;
   logic signed [32:0] hl_ff, hr_ff;
   logic               sat0_ff, sat1_ff, sat2_ff;

   logic signed [63:0] m0_ff, m1_ff, x0_ff, x1_ff, y0_ff, y1_ff;
   logic signed [64:0] x2_ff, y2_ff, e0_ff, e1_ff;
   logic signed [65:0] sm_ff, sx_ff, sy_ff, se_ff;

   cffd_pkg::clip_type cm, cx, cy, ce;
   cffd_pkg::rsp_type  flux_ff;

   // Register the operands, form pressure sum and enthalpy terms.
   always_ff @(posedge clock) begin
      if (en) begin
         ql_ff   <= velo_l.qs;
         qr_ff   <= velo_r.qs;
         sat0_ff <= velo_l.sat | velo_r.sat;
         rl_ff   <= item.left_density;
         rr_ff   <= item.right_density;
         xl_ff   <= item.left_xmom;
         xr_ff   <= item.right_xmom;
         yl_ff   <= item.left_ymom;
         yr_ff   <= item.right_ymom;
         nx_ff   <= item.face_nx;
         ny_ff   <= item.face_ny;
         psum_ff <= 32'(item.left_pressure) + 32'(item.right_pressure);
         hl_ff   <= $signed({2'b00, item.left_pressure}) + 33'(item.left_energy);
         hr_ff   <= $signed({2'b00, item.right_pressure}) + 33'(item.right_energy);
      end
   end

   // Multiply, one register behind each product.
   always_ff @(posedge clock) begin
      if (en) begin
         m0_ff   <= ql_ff * $signed({1'b0, rl_ff});
         m1_ff   <= qr_ff * $signed({1'b0, rr_ff});
         x0_ff   <= ql_ff * xl_ff;
         x1_ff   <= qr_ff * xr_ff;
         x2_ff   <= $signed({1'b0, psum_ff}) * nx_ff;
         y0_ff   <= ql_ff * yl_ff;
         y1_ff   <= qr_ff * yr_ff;
         y2_ff   <= $signed({1'b0, psum_ff}) * ny_ff;
         e0_ff   <= ql_ff * hl_ff;
         e1_ff   <= qr_ff * hr_ff;
         sat1_ff <= sat0_ff;
      end
   end

   // Sum the terms and add the rounding half.
   always_ff @(posedge clock) begin
      if (en) begin
         sm_ff   <= 66'(m0_ff) + 66'(m1_ff) + cffd_pkg::FLUX_RND;
         sx_ff   <= 66'(x0_ff) + 66'(x1_ff) + 66'(x2_ff) + cffd_pkg::FLUX_RND;
         sy_ff   <= 66'(y0_ff) + 66'(y1_ff) + 66'(y2_ff) + cffd_pkg::FLUX_RND;
         se_ff   <= 66'(e0_ff) + 66'(e1_ff) + cffd_pkg::FLUX_RND;
         sat2_ff <= sat1_ff;
      end
   end

   assign cm = cffd_pkg::clip_flux(sm_ff);
   assign cx = cffd_pkg::clip_flux(sx_ff);
   assign cy = cffd_pkg::clip_flux(sy_ff);
   assign ce = cffd_pkg::clip_flux(se_ff);

   // Scale down, clip and collect the saturation flag.
   always_ff @(posedge clock) begin
      if (en) begin
         flux_ff.mass_flux   <= cm.val;
         flux_ff.xmom_flux   <= cx.val;
         flux_ff.ymom_flux   <= cy.val;
         flux_ff.energy_flux <= ce.val;
         flux_ff.saturated   <= sat2_ff | cm.sat | cx.sat | cy.sat | ce.sat;
      end
   end

   assign flux = flux_ff;

endmodule

// ===== rtl/core/cffd_skid.sv =====
module cffd_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cffd_pkg::rsp_type in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output cffd_pkg::rsp_type out_word
);

   logic              main_v_ff, skid_v_ff;
   cffd_pkg::rsp_type main_ff, skid_ff;

   // Control: refill the output from the skid first, else from the input.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_ready || !main_v_ff) begin
         if (skid_v_ff) begin
            main_v_ff <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            main_v_ff <= in_valid;
         end
      end else if (in_valid && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   // Payload follows the same choices.
   always_ff @(posedge clock) begin
      if (out_ready || !main_v_ff) begin
         main_ff <= skid_v_ff ? skid_ff : in_word;
      end else if (in_valid && !skid_v_ff) begin
         skid_ff <= in_word;
      end
   end

   assign in_ready  = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_word  = main_ff;

endmodule

// ===== rtl/core/cffd_checker.sv =====
`include "central_face_flux_2d_core_defines.svh"

module cffd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_mass_flux
);

   // Reset empties the output.
   `CFFD_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // Input backpressure only while a word waits at the output.
   `CFFD_ASSERT_IMP(a_stall_has_out, clock, reset, !req_ready, rsp_valid)
   // Input backpressure only after the output was stalled.
   `CFFD_ASSERT_IMP(a_stall_cause, clock, reset, !req_ready, $past(rsp_valid && !rsp_ready))
   // Hold a stalled output word.
   `CFFD_ASSERT_NXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_mass_flux))

endmodule

bind central_face_flux_2d_core cffd_checker u_cffd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_mass_flux (rsp_ch.mass_flux)
);

// ===== bench/tb_central_face_flux_2d_core.sv =====
module tb_central_face_flux_2d_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_FACES = 500;
   localparam int DRAIN_CYCLES = cffd_pkg::PIPE_LAT + 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cffd_req_if req_ch();
   cffd_rsp_if rsp_ch();

   central_face_flux_2d_core dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #1 clock = ~clock;

   // One directed face, with an optional hand-typed flux
   typedef struct {
      cffd_pkg::item_type face;
      bit                 typed;
      cffd_pkg::rsp_type  flux;
   } face_row_type;

   cffd_pkg::rsp_type expected_flux_q[$];
   int      fail_count  = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   // Contravariant velocity: exact dot product over density, truncated, clipped
   function automatic logic signed [31:0] contra_velocity(
      input logic signed [31:0] xm, input logic signed [31:0] ym,
      input logic signed [31:0] nx, input logic signed [31:0] ny,
      input logic [30:0] rho, inout bit sat);
      logic signed [127:0] wxm, wym, wnx, wny, wrho, dot, mag, q;
      bit neg;
      wxm  = xm;
      wym  = ym;
      wnx  = nx;
      wny  = ny;
      wrho = {97'd0, rho};
      if (wrho == 0) wrho = 1;
      dot = wxm * wnx + wym * wny;
      neg = dot < 0;
      mag = neg ? -dot : dot;
      q   = mag / wrho;
      if (!neg) begin
         if (q > 128'sd2147483647) begin
            sat = 1;
            return cffd_pkg::Q_MAX;
         end
         return q[31:0];
      end
      if (q > 128'sd2147483648) begin
         sat = 1;
         return cffd_pkg::Q_MIN;
      end
      q = -q;
      return q[31:0];
   endfunction

   // Halve the exact Q32.32 sum into Q16.16, round half up, clip
   function automatic logic signed [31:0] flux_round(
      input logic signed [127:0] s, inout bit sat);
      logic signed [127:0] r;
      r = (s + 128'sd65536) >>> 17;
      if (r > 128'sd2147483647) begin
         sat = 1;
         return cffd_pkg::Q_MAX;
      end
      if (r < -128'sd2147483648) begin
         sat = 1;
         return cffd_pkg::Q_MIN;
      end
      return r[31:0];
   endfunction

   function automatic cffd_pkg::rsp_type predict_face_flux(input cffd_pkg::item_type f);
      cffd_pkg::rsp_type r;
      bit sat;
      logic signed [127:0] qsl, qsr, rl, rr, xl, xr, yl, yr, el, er, pl, pr, nx, ny;
      sat = 0;
      qsl = contra_velocity(f.left_xmom, f.left_ymom, f.face_nx, f.face_ny,
                            f.left_density, sat);
      qsr = contra_velocity(f.right_xmom, f.right_ymom, f.face_nx, f.face_ny,
                            f.right_density, sat);
      rl = {97'd0, f.left_density};
      rr = {97'd0, f.right_density};
      pl = {97'd0, f.left_pressure};
      pr = {97'd0, f.right_pressure};
      xl = f.left_xmom;
      xr = f.right_xmom;
      yl = f.left_ymom;
      yr = f.right_ymom;
      el = f.left_energy;
      er = f.right_energy;
      nx = f.face_nx;
      ny = f.face_ny;
      r.mass_flux   = flux_round(qsl * rl + qsr * rr, sat);
      r.xmom_flux   = flux_round(qsl * xl + qsr * xr + (pl + pr) * nx, sat);
      r.ymom_flux   = flux_round(qsl * yl + qsr * yr + (pl + pr) * ny, sat);
      r.energy_flux = flux_round(qsl * (pl + el) + qsr * (pr + er), sat);
      r.saturated   = sat;
      return r;
   endfunction

   // Signed word: extremes, full range, or a moderate physical magnitude
   function automatic logic [31:0] pick_word();
      int k;
      k = $urandom_range(0, 9);
      case (k)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      endcase
   endfunction

   function automatic logic [30:0] pick_positive();
      int k;
      k = $urandom_range(0, 9);
      case (k)
         0: return 31'h7FFF_FFFF;
         1: return 31'd0;
         2, 3: return 31'($urandom());
         default: return 31'($urandom_range(1, 32'h0004_0000));
      endcase
   endfunction

   function automatic cffd_pkg::item_type random_face();
      cffd_pkg::item_type f;
      f.left_density   = pick_positive();
      f.left_xmom      = pick_word();
      f.left_ymom      = pick_word();
      f.left_energy    = pick_word();
      f.left_pressure  = pick_positive();
      f.right_density  = pick_positive();
      f.right_xmom     = pick_word();
      f.right_ymom     = pick_word();
      f.right_energy   = pick_word();
      f.right_pressure = pick_positive();
      f.face_nx        = pick_word();
      f.face_ny        = pick_word();
      return f;
   endfunction

   // Drive one word at the falling edge and hold it until accepted
   task automatic send_face(input cffd_pkg::item_type f);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid          = 1'b1;
      req_ch.left_density   = f.left_density;
      req_ch.left_xmom      = f.left_xmom;
      req_ch.left_ymom      = f.left_ymom;
      req_ch.left_energy    = f.left_energy;
      req_ch.left_pressure  = f.left_pressure;
      req_ch.right_density  = f.right_density;
      req_ch.right_xmom     = f.right_xmom;
      req_ch.right_ymom     = f.right_ymom;
      req_ch.right_energy   = f.right_energy;
      req_ch.right_pressure = f.right_pressure;
      req_ch.face_nx        = f.face_nx;
      req_ch.face_ny        = f.face_ny;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Receiver back-pressure, changed at the falling edge
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Predict on each accepted face, check each accepted flux word
   always @(posedge clock) begin
      cffd_pkg::rsp_type e;
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_flux_q.push_back(predict_face_flux(cffd_pkg::item_type'({
            req_ch.left_density, req_ch.left_xmom, req_ch.left_ymom,
            req_ch.left_energy, req_ch.left_pressure, req_ch.right_density,
            req_ch.right_xmom, req_ch.right_ymom, req_ch.right_energy,
            req_ch.right_pressure, req_ch.face_nx, req_ch.face_ny})));
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_flux_q.size() == 0) begin
            $error("flux word with no face pending");
            fail_count++;
         end else begin
            e = expected_flux_q.pop_front();
            if (rsp_ch.mass_flux !== e.mass_flux) begin
               $error("mass_flux exp %h got %h", e.mass_flux, rsp_ch.mass_flux);
               fail_count++;
            end
            if (rsp_ch.xmom_flux !== e.xmom_flux) begin
               $error("xmom_flux exp %h got %h", e.xmom_flux, rsp_ch.xmom_flux);
               fail_count++;
            end
            if (rsp_ch.ymom_flux !== e.ymom_flux) begin
               $error("ymom_flux exp %h got %h", e.ymom_flux, rsp_ch.ymom_flux);
               fail_count++;
            end
            if (rsp_ch.energy_flux !== e.energy_flux) begin
               $error("energy_flux exp %h got %h", e.energy_flux, rsp_ch.energy_flux);
               fail_count++;
            end
            if (rsp_ch.saturated !== e.saturated) begin
               $error("saturated exp %b got %b", e.saturated, rsp_ch.saturated);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Directed faces: zero state, zero density, extremes of every field, unit flow, rounding ties, random rows
   function automatic void build_directed(ref face_row_type rows[$]);
      face_row_type r;
      cffd_pkg::item_type z;
      z = '0;
      r.typed = 1;
      r.flux  = '0;
      r.face  = z;
      rows.push_back(r);
      // zero density with zero momentum still gives zero flux
      r.face = z;
      r.face.face_nx = 32'sh0001_0000;
      rows.push_back(r);
      r.typed = 0;
      r.face = z;
      r.face.left_density = 31'd0;
      r.face.right_density = 31'd0;
      r.face.left_xmom = 32'sh0000_0100;
      r.face.right_xmom = 32'sh8000_0000;
      r.face.face_nx = 32'sh7FFF_FFFF;
      rows.push_back(r);
      r.face = '1;
      rows.push_back(r);
      r.face = z;
      r.face.left_density  = 31'h7FFF_FFFF;
      r.face.right_density = 31'h7FFF_FFFF;
      r.face.left_pressure  = 31'h7FFF_FFFF;
      r.face.right_pressure = 31'h7FFF_FFFF;
      r.face.face_nx = 32'sh8000_0000;
      r.face.face_ny = 32'sh7FFF_FFFF;
      rows.push_back(r);
      r.face.left_xmom  = 32'sh8000_0000;
      r.face.left_ymom  = 32'sh8000_0000;
      r.face.right_xmom = 32'sh7FFF_FFFF;
      r.face.right_ymom = 32'sh7FFF_FFFF;
      r.face.left_energy  = 32'sh8000_0000;
      r.face.right_energy = 32'sh7FFF_FFFF;
      rows.push_back(r);
      r.face.left_density  = 31'd1;
      r.face.right_density = 31'd1;
      rows.push_back(r);
      // unit flow: rho 1, u 1, nx 1, p 1
      r.face = z;
      r.face.left_density  = 31'h0001_0000;
      r.face.right_density = 31'h0001_0000;
      r.face.left_xmom  = 32'sh0001_0000;
      r.face.right_xmom = 32'sh0001_0000;
      r.face.left_pressure  = 31'h0001_0000;
      r.face.right_pressure = 31'h0001_0000;
      r.face.left_energy  = 32'sh0002_8000;
      r.face.right_energy = 32'sh0002_8000;
      r.face.face_nx = 32'sh0001_0000;
      rows.push_back(r);
      // rounding ties on the final shift
      r.face.face_nx = 32'sh0000_0001;
      r.face.face_ny = -32'sh0000_0001;
      r.face.left_ymom = -32'sh0000_0003;
      rows.push_back(r);
      for (int i = 0; i < 12; i++) begin
         r.face = random_face();
         rows.push_back(r);
      end
   endfunction

   initial begin
      face_row_type      rows[$];
      cffd_pkg::rsp_type got;
      int        phase_send[4] = '{0, 52, 0, 18};
      int        phase_recv[4] = '{0, 0, 52, 18};

      req_ch.valid = 1'b0;
      {req_ch.left_density, req_ch.left_xmom, req_ch.left_ymom, req_ch.left_energy,
       req_ch.left_pressure, req_ch.right_density, req_ch.right_xmom, req_ch.right_ymom,
       req_ch.right_energy, req_ch.right_pressure, req_ch.face_nx, req_ch.face_ny} = '0;
      rsp_ch.ready = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Typed rows are checked against the hand value too
      build_directed(rows);
      foreach (rows[i]) begin
         if (rows[i].typed) begin
            got = predict_face_flux(rows[i].face);
            if (got !== rows[i].flux) begin
               $error("directed row %0d flux exp %h got %h", i, rows[i].flux, got);
               fail_count++;
            end
         end
         send_face(rows[i].face);
      end

      // Random faces across the back-pressure phases
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         for (int i = 0; i < RANDOM_FACES / 4; i++) send_face(random_face());
      end
      @(negedge clock);
      req_ch.valid = 1'b0;

      wait (expected_flux_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
